/* hdl/spa_pkg.sv */
// spa_pkg: operation codes, fixed field widths and item size rounding constants
// for the slot pool allocator. No dependencies.
`timescale 1ns / 1ps
package spa_pkg;
	localparam int OP_W          = 3;
	localparam int POOL_HANDLE_W = 4;
	localparam int HANDLE_W      = 7;
	localparam int ITEM_BYTES_W  = 16;
	localparam int ITEM_SIZE_W   = 17;
	localparam int GROW_W        = 7;
	localparam int OFFSET_W      = 22;
	localparam int PROD_W        = HANDLE_W + ITEM_SIZE_W;

	localparam logic [OP_W-1:0] OP_CREATE     = 3'd0;
	localparam logic [OP_W-1:0] OP_DESTROY    = 3'd1;
	localparam logic [OP_W-1:0] OP_FLUSH      = 3'd2;
	localparam logic [OP_W-1:0] OP_ALLOC      = 3'd3;
	localparam logic [OP_W-1:0] OP_GET_OFFSET = 3'd4;
	localparam logic [OP_W-1:0] OP_FREE       = 3'd5;
	localparam logic [OP_W-1:0] OP_FIND_FIRST = 3'd6;
	localparam logic [OP_W-1:0] OP_FIND_NEXT  = 3'd7;

	localparam logic [ITEM_SIZE_W-1:0] ALIGN_ADD  = 17'd7;
	localparam logic [ITEM_SIZE_W-1:0] ALIGN_MASK = ~17'd7;
endpackage

/* hdl/spa_ram.sv */
// spa_ram: generic single-write, single-read synchronous RAM with registered
// read data. No dependencies.
`timescale 1ns / 1ps
module spa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hdl/spa_lowbit.sv */
// spa_lowbit: lowest set bit of a vector, as a one-hot mask and as an index.
// No dependencies.
`timescale 1ns / 1ps
module spa_lowbit #(
	parameter int W   = 8,
	parameter int IXW = 3
) (
	input  logic [W-1:0]   vec,
	output logic           found,
	output logic [IXW-1:0] index,
	output logic [W-1:0]   onehot
);
	assign onehot = vec & (~vec + W'(1));
	assign found  = |vec;

	always_comb begin
		index = '0;
		for (int i = 0; i < W; i++) begin
			if (onehot[i]) begin
				index = index | IXW'(i);
			end
		end
	end
endmodule

/* hdl/slot_pool_allocator.sv */
// slot_pool_allocator: top level, pool table with one bitmap row per pool.
// Depends on spa_pkg, spa_ram and spa_lowbit.
`timescale 1ns / 1ps
// For every request the pool entry (capacity, item size, growth
// step and slot bitmap) is read from one synchronous RAM at the accept edge and
// modified and written back in the following cycle, where one priority encoder
// finds the lowest free or taken slot. busy is high during that cycle only; the
// result then stands on ok, handle_out and byte_offset for exactly one cycle
// with done high, and a new start may be accepted in that same cycle; no new
// request enters while busy is high. Results cannot be held off: the
// receiver must take each one in the cycle that done marks. Pool used flags sit
// in flip-flops cleared by reset; the RAM needs no clearing pass.
module slot_pool_allocator #(
	parameter int NUM_POOLS = 8,
	parameter int MAX_SLOTS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [spa_pkg::OP_W-1:0]             operation,
	input  logic [spa_pkg::POOL_HANDLE_W-1:0]    pool_handle,
	input  logic [spa_pkg::HANDLE_W-1:0]         slot_handle,
	input  logic [spa_pkg::HANDLE_W-1:0]         slot_count,
	input  logic [spa_pkg::ITEM_BYTES_W-1:0]     item_bytes,
	input  logic [spa_pkg::GROW_W-1:0]           grow_step,
	output logic                                 done,
	output logic                                 ok,
	output logic [spa_pkg::HANDLE_W-1:0]         handle_out,
	output logic [spa_pkg::OFFSET_W-1:0]         byte_offset
);
	import spa_pkg::*;

	localparam int AW   = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
	localparam int IW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW   = $clog2(MAX_SLOTS + 1);
	localparam int NW   = ((CW > GROW_W) ? CW : GROW_W) + 1;
	localparam int CMPW = ((CW > HANDLE_W) ? CW : HANDLE_W) + 1;
	localparam int EW   = CW + ITEM_SIZE_W + GROW_W + MAX_SLOTS;
	localparam int PXW  = POOL_HANDLE_W + AW;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EX   = 1'b1;

	logic                   state_q;
	logic                   done_q;
	logic [NUM_POOLS-1:0]   used_q;

	logic                   accept;
	logic [PXW-1:0]         ph_ext;
	logic [AW-1:0]          ph_addr;
	logic                   pool_ok;
	logic [NUM_POOLS-1:0]   ph_sel;
	logic                   free_found;
	logic [AW-1:0]          free_idx;
	logic [NUM_POOLS-1:0]   free_low;

	logic [OP_W-1:0]        op_s1;
	logic                   pool_ok_s1;
	logic                   create_ok_s1;
	logic [AW-1:0]          addr_s1;
	logic [NUM_POOLS-1:0]   sel_s1;
	logic [HANDLE_W-1:0]    sh_s1;
	logic [HANDLE_W-1:0]    cnt_s1;
	logic [ITEM_SIZE_W-1:0] size_s1;
	logic [GROW_W-1:0]      step_s1;

	logic                   ram_we;
	logic [EW-1:0]          ram_wdata;
	logic [EW-1:0]          ram_rdata;

	logic [CW-1:0]          cap;
	logic [ITEM_SIZE_W-1:0] size_rd;
	logic [GROW_W-1:0]      grow;
	logic [MAX_SLOTS-1:0]   row;
	logic [MAX_SLOTS-1:0]   cap_mask;
	logic [MAX_SLOTS-1:0]   cap_bit;
	logic [MAX_SLOTS-1:0]   idx_bit;
	logic [MAX_SLOTS-1:0]   from_mask;
	logic [MAX_SLOTS-1:0]   scan_vec;
	logic                   scan_found;
	logic [IW-1:0]          scan_idx;
	logic [MAX_SLOTS-1:0]   scan_low;
	logic [HANDLE_W-1:0]    idx;
	logic                   slot_hit;
	logic [NW-1:0]          ncap;
	logic                   grow_ok;
	logic [IW-1:0]          alloc_slot;
	logic [IW:0]            alloc_num;
	logic [IW:0]            found_num;
	logic [AW:0]            pool_num;
	logic [PROD_W-1:0]      prod;

	logic                   res_ok;
	logic [HANDLE_W-1:0]    res_handle;
	logic [OFFSET_W-1:0]    res_off;

	assign busy   = (state_q == ST_EX);
	assign accept = start && !busy;
	assign done   = done_q;

	// handle decode at the accept edge
	assign ph_ext  = {{AW{1'b0}}, pool_handle} - PXW'(1);
	assign ph_addr = ph_ext[AW-1:0];
	assign pool_ok = (pool_handle != '0) && (ph_ext < PXW'(NUM_POOLS)) && used_q[ph_addr];

	always_comb begin
		for (int i = 0; i < NUM_POOLS; i++) begin
			ph_sel[i] = (AW'(i) == ph_addr);
		end
	end

	spa_lowbit #(.W(NUM_POOLS), .IXW(AW)) u_free_pool (
		.vec    (~used_q),
		.found  (free_found),
		.index  (free_idx),
		.onehot (free_low)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1        <= operation;
			pool_ok_s1   <= pool_ok;
			create_ok_s1 <= free_found && (int'(slot_count) <= MAX_SLOTS);
			addr_s1      <= (operation == OP_CREATE) ? free_idx : ph_addr;
			sel_s1       <= (operation == OP_CREATE) ? free_low : ph_sel;
			sh_s1        <= slot_handle;
			cnt_s1       <= slot_count;
			size_s1      <= (ITEM_SIZE_W'({1'b0, item_bytes}) + ALIGN_ADD) & ALIGN_MASK;
			step_s1      <= grow_step;
		end
	end

	spa_ram #(.WIDTH(EW), .DEPTH(NUM_POOLS)) u_pool_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (ram_wdata),
		.raddr (ph_addr),
		.rdata (ram_rdata)
	);

	// entry fields
	assign cap     = ram_rdata[EW-1 -: CW];
	assign size_rd = ram_rdata[MAX_SLOTS+GROW_W +: ITEM_SIZE_W];
	assign grow    = ram_rdata[MAX_SLOTS +: GROW_W];
	assign row     = ram_rdata[MAX_SLOTS-1:0];
	assign idx     = sh_s1 - HANDLE_W'(1);

	always_comb begin
		for (int i = 0; i < MAX_SLOTS; i++) begin
			cap_mask[i]  = (CMPW'(i) < CMPW'(cap));
			cap_bit[i]   = (CMPW'(i) == CMPW'(cap));
			idx_bit[i]   = (CMPW'(i) == CMPW'(idx));
			from_mask[i] = (CMPW'(i) >= CMPW'(sh_s1));
		end
	end

	always_comb begin
		if (op_s1 == OP_ALLOC) begin
			scan_vec = ~row & cap_mask;
		end else if (op_s1 == OP_FIND_FIRST) begin
			scan_vec = row & cap_mask;
		end else begin
			scan_vec = row & cap_mask & from_mask;
		end
	end

	spa_lowbit #(.W(MAX_SLOTS), .IXW(IW)) u_scan (
		.vec    (scan_vec),
		.found  (scan_found),
		.index  (scan_idx),
		.onehot (scan_low)
	);

	assign slot_hit   = (sh_s1 != '0) && (|(row & cap_mask & idx_bit));
	assign ncap       = NW'(cap) + NW'(grow);
	assign grow_ok    = (grow != '0) && (ncap <= NW'(MAX_SLOTS));
	assign alloc_slot = scan_found ? scan_idx : IW'(cap);
	assign alloc_num  = {1'b0, alloc_slot} + (IW+1)'(1);
	assign found_num  = {1'b0, scan_idx} + (IW+1)'(1);
	assign pool_num   = {1'b0, addr_s1} + (AW+1)'(1);
	assign prod       = PROD_W'(idx) * PROD_W'(size_rd);

	always_comb begin
		res_ok     = 1'b0;
		res_handle = '0;
		res_off    = '0;
		ram_we     = 1'b0;
		ram_wdata  = ram_rdata;
		if (state_q == ST_EX) begin
			if (op_s1 == OP_CREATE) begin
				if (create_ok_s1) begin
					res_ok     = 1'b1;
					res_handle = HANDLE_W'(pool_num);
					ram_we     = 1'b1;
					ram_wdata  = {CW'(cnt_s1), size_s1, step_s1, {MAX_SLOTS{1'b0}}};
				end
			end else if (pool_ok_s1) begin
				unique case (op_s1) inside
					OP_DESTROY: begin
						res_ok = 1'b1;
					end
					OP_FLUSH: begin
						res_ok    = 1'b1;
						ram_we    = 1'b1;
						ram_wdata = {cap, size_rd, grow, {MAX_SLOTS{1'b0}}};
					end
					OP_ALLOC: begin
						if (scan_found) begin
							res_ok     = 1'b1;
							res_handle = HANDLE_W'(alloc_num);
							ram_we     = 1'b1;
							ram_wdata  = {cap, size_rd, grow, row | scan_low};
						end else if (grow_ok) begin
							res_ok     = 1'b1;
							res_handle = HANDLE_W'(alloc_num);
							ram_we     = 1'b1;
							ram_wdata  = {CW'(ncap), size_rd, grow, row | cap_bit};
						end
					end
					OP_GET_OFFSET: begin
						if (slot_hit) begin
							res_ok  = 1'b1;
							res_off = prod[OFFSET_W-1:0];
						end
					end
					OP_FREE: begin
						if (slot_hit) begin
							res_ok    = 1'b1;
							ram_we    = 1'b1;
							ram_wdata = {cap, size_rd, grow, row & ~idx_bit};
						end
					end
					OP_FIND_FIRST, OP_FIND_NEXT: begin
						if (scan_found) begin
							res_ok     = 1'b1;
							res_handle = HANDLE_W'(found_num);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			used_q  <= '0;
		end else begin
			done_q <= (state_q == ST_EX);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EX;
					end
				end
				ST_EX: begin
					state_q <= ST_IDLE;
					if (op_s1 == OP_CREATE && create_ok_s1) begin
						used_q <= used_q | sel_s1;
					end else if (op_s1 == OP_DESTROY && pool_ok_s1) begin
						used_q <= used_q & ~sel_s1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EX) begin
			ok          <= res_ok;
			handle_out  <= res_handle;
			byte_offset <= res_off;
		end
	end

	a_accept_ex: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EX))
		else $error("accepted beat did not enter execute");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EX) |=> done_q)
		else $error("execute cycle gave no result beat");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !ok) |-> (handle_out == '0 && byte_offset == '0))
		else $error("failed result carries nonzero payload");

	a_we_ex: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_EX))
		else $error("pool ram written outside execute");

	a_create_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EX && op_s1 == OP_CREATE && create_ok_s1)
		|=> ((used_q & sel_s1) == sel_s1))
		else $error("created pool not marked used");
endmodule

/* dv/tb_slot_pool_allocator.sv */
// tb_slot_pool_allocator: self-checking testbench for the slot pool allocator.
// Directed table then biased random requests, checked against typed rows or a pool model.
// Depends on spa_pkg and slot_pool_allocator.
`timescale 1ns / 1ps
module tb_slot_pool_allocator;
	import spa_pkg::*;

	localparam int NUM_POOLS = 8;
	localparam int MAX_SLOTS = 64;
	localparam int RANDOM_REQS = 1100;
	localparam int QUIET_TAIL = 150;

	typedef struct {
		logic [OP_W-1:0]          op;
		logic [POOL_HANDLE_W-1:0] ph;
		logic [HANDLE_W-1:0]      sh;
		logic [HANDLE_W-1:0]      cnt;
		logic [ITEM_BYTES_W-1:0]  bytes;
		logic [GROW_W-1:0]        step;
		bit                       typed;
		logic                     e_ok;
		logic [HANDLE_W-1:0]      e_h;
		logic [OFFSET_W-1:0]      e_off;
	} req_t;

	typedef struct {
		logic                ok;
		logic [HANDLE_W-1:0] h;
		logic [OFFSET_W-1:0] off;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [OP_W-1:0] operation;
	logic [POOL_HANDLE_W-1:0] pool_handle;
	logic [HANDLE_W-1:0] slot_handle;
	logic [HANDLE_W-1:0] slot_count;
	logic [ITEM_BYTES_W-1:0] item_bytes;
	logic [GROW_W-1:0] grow_step;
	logic done;
	logic ok;
	logic [HANDLE_W-1:0] handle_out;
	logic [OFFSET_W-1:0] byte_offset;

	bit pool_used[NUM_POOLS];
	int pool_cap[NUM_POOLS];
	logic [ITEM_SIZE_W-1:0] pool_size[NUM_POOLS];
	int pool_grow[NUM_POOLS];
	logic [63:0] pool_taken[NUM_POOLS];

	outcome_t outcome_q[$];
	req_t directed_rows[$];
	int mismatch_count = 0;

	slot_pool_allocator #(
		.NUM_POOLS(NUM_POOLS),
		.MAX_SLOTS(MAX_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.pool_handle(pool_handle),
		.slot_handle(slot_handle),
		.slot_count(slot_count),
		.item_bytes(item_bytes),
		.grow_step(grow_step),
		.done(done),
		.ok(ok),
		.handle_out(handle_out),
		.byte_offset(byte_offset)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 40) begin
			$display("mismatch @%0t: %s", $realtime, msg);
		end
	endtask

	function automatic int lowest_slot(int p, int from, bit want);
		for (int i = from; i < pool_cap[p]; i++) begin
			if (pool_taken[p][i] == want) begin
				return i;
			end
		end
		return pool_cap[p];
	endfunction

	function automatic outcome_t pool_outcome(req_t r);
		outcome_t o;
		int p;
		int idx;
		int i;
		int ncap;
		bit pool_ok;
		o = '{1'b0, '0, '0};
		p = int'(r.ph) - 1;
		pool_ok = (p >= 0 && p < NUM_POOLS) ? pool_used[p] : 1'b0;
		idx = int'(r.sh) - 1;
		if (r.op == OP_CREATE) begin
			i = 0;
			while (i < NUM_POOLS && pool_used[i]) begin
				i++;
			end
			if (i < NUM_POOLS && int'(r.cnt) <= MAX_SLOTS) begin
				pool_used[i] = 1'b1;
				pool_cap[i] = int'(r.cnt);
				pool_size[i] = ({1'b0, r.bytes} + 17'd7) & ~17'd7;
				pool_grow[i] = int'(r.step);
				pool_taken[i] = '0;
				o.ok = 1'b1;
				o.h = HANDLE_W'(i + 1);
			end
		end else if (pool_ok) begin
			case (r.op)
				OP_DESTROY: begin
					pool_used[p] = 1'b0;
					pool_taken[p] = '0;
					o.ok = 1'b1;
				end
				OP_FLUSH: begin
					pool_taken[p] = '0;
					o.ok = 1'b1;
				end
				OP_ALLOC: begin
					i = lowest_slot(p, 0, 1'b0);
					if (i == pool_cap[p]) begin
						ncap = pool_cap[p] + pool_grow[p];
						if (pool_grow[p] != 0 && ncap <= MAX_SLOTS) begin
							pool_cap[p] = ncap;
							pool_taken[p][i] = 1'b1;
							o.ok = 1'b1;
							o.h = HANDLE_W'(i + 1);
						end
					end else begin
						pool_taken[p][i] = 1'b1;
						o.ok = 1'b1;
						o.h = HANDLE_W'(i + 1);
					end
				end
				OP_GET_OFFSET, OP_FREE: begin
					if (r.sh != 0 && idx < pool_cap[p] && pool_taken[p][idx]) begin
						o.ok = 1'b1;
						if (r.op == OP_FREE) begin
							pool_taken[p][idx] = 1'b0;
						end else begin
							o.off = OFFSET_W'(idx * int'(pool_size[p]));
						end
					end
				end
				default: begin
					i = lowest_slot(p, (r.op == OP_FIND_FIRST) ? 0 : int'(r.sh), 1'b1);
					if (i < pool_cap[p]) begin
						o.ok = 1'b1;
						o.h = HANDLE_W'(i + 1);
					end
				end
			endcase
		end
		return o;
	endfunction

	function automatic int pick_pool_handle();
		int s;
		if ($urandom_range(99) < 85) begin
			s = $urandom_range(NUM_POOLS - 1);
			for (int k = 0; k < NUM_POOLS; k++) begin
				if (pool_used[(s + k) % NUM_POOLS]) begin
					return (s + k) % NUM_POOLS + 1;
				end
			end
			return s + 1;
		end
		return $urandom_range(15);
	endfunction

	function automatic int pick_slot_handle(int ph, bit want_taken);
		int p;
		int s;
		p = ph - 1;
		if ($urandom_range(99) < 10 || p < 0 || p >= NUM_POOLS) begin
			return $urandom_range(127);
		end
		if (want_taken && $urandom_range(99) < 75) begin
			s = $urandom_range(63);
			for (int k = 0; k < 64; k++) begin
				if (pool_taken[p][(s + k) % 64]) begin
					return (s + k) % 64 + 1;
				end
			end
		end
		return $urandom_range(pool_cap[p] + 1);
	endfunction

	function automatic req_t random_request();
		req_t r;
		int w;
		r = '{default: '0};
		w = $urandom_range(99);
		if (w < 8) begin
			r.op = OP_CREATE;
		end else if (w < 12) begin
			r.op = OP_DESTROY;
		end else if (w < 15) begin
			r.op = OP_FLUSH;
		end else if (w < 50) begin
			r.op = OP_ALLOC;
		end else if (w < 65) begin
			r.op = OP_GET_OFFSET;
		end else if (w < 80) begin
			r.op = OP_FREE;
		end else if (w < 88) begin
			r.op = OP_FIND_FIRST;
		end else begin
			r.op = OP_FIND_NEXT;
		end
		r.ph = POOL_HANDLE_W'(pick_pool_handle());
		r.sh = HANDLE_W'(pick_slot_handle(int'(r.ph), r.op != OP_FIND_NEXT));
		w = $urandom_range(99);
		r.cnt = (w < 60) ? HANDLE_W'($urandom_range(8)) :
			(w < 92) ? HANDLE_W'($urandom_range(MAX_SLOTS)) : HANDLE_W'($urandom_range(127));
		r.bytes = ($urandom_range(3) == 0) ? ITEM_BYTES_W'($urandom_range(65535)) :
			ITEM_BYTES_W'($urandom_range(64));
		w = $urandom_range(99);
		r.step = (w < 70) ? GROW_W'($urandom_range(8)) :
			(w < 90) ? GROW_W'($urandom_range(MAX_SLOTS)) : GROW_W'($urandom_range(127));
		return r;
	endfunction

	task automatic add_row(input logic [OP_W-1:0] op, input int ph, input int sh,
			input int cnt, input int bytes, input int step, input bit typed,
			input logic e_ok, input int e_h, input int e_off);
		req_t r;
		r.op = op;
		r.ph = POOL_HANDLE_W'(ph);
		r.sh = HANDLE_W'(sh);
		r.cnt = HANDLE_W'(cnt);
		r.bytes = ITEM_BYTES_W'(bytes);
		r.step = GROW_W'(step);
		r.typed = typed;
		r.e_ok = e_ok;
		r.e_h = HANDLE_W'(e_h);
		r.e_off = OFFSET_W'(e_off);
		directed_rows.push_back(r);
	endtask

	task automatic load_directed();
		add_row(OP_ALLOC,      1,  0,  0,     0,   0, 1, 0, 0, 0);
		add_row(OP_CREATE,     0,  0, 65,     8,   1, 1, 0, 0, 0);
		add_row(OP_CREATE,     0,  0,  0,     1,   1, 1, 1, 1, 0);
		add_row(OP_ALLOC,      1,  0,  0,     0,   0, 1, 1, 1, 0);
		add_row(OP_GET_OFFSET, 1,  1,  0,     0,   0, 1, 1, 0, 0);
		add_row(OP_CREATE,     0,  0, 64, 65535,   0, 1, 1, 2, 0);
		add_row(OP_ALLOC,      2,  0,  0,     0,   0, 0, 0, 0, 0);
		add_row(OP_GET_OFFSET, 2,  0,  0,     0,   0, 1, 0, 0, 0);
		add_row(OP_GET_OFFSET, 2, 65,  0,     0,   0, 1, 0, 0, 0);
		add_row(OP_GET_OFFSET, 2, 64,  0,     0,   0, 1, 0, 0, 0);
		add_row(OP_FREE,       2,  1,  0,     0,   0, 1, 1, 0, 0);
		add_row(OP_FIND_FIRST, 2,  0,  0,     0,   0, 1, 0, 0, 0);
		add_row(OP_ALLOC,      2,  0,  0,     0,   0, 0, 0, 0, 0);
		add_row(OP_ALLOC,      2,  0,  0,     0,   0, 0, 0, 0, 0);
		add_row(OP_FIND_NEXT,  2,  1,  0,     0,   0, 0, 0, 0, 0);
		add_row(OP_FIND_NEXT,  2, 64,  0,     0,   0, 1, 0, 0, 0);
		add_row(OP_FLUSH,      2,  0,  0,     0,   0, 1, 1, 0, 0);
		add_row(OP_DESTROY,    0,  0,  0,     0,   0, 1, 0, 0, 0);
		add_row(OP_FREE,      15,  1,  0,     0,   0, 1, 0, 0, 0);
		add_row(OP_CREATE,     0,  0, 64,     0,  64, 1, 1, 3, 0);
		add_row(OP_CREATE,     9,  0,  1, 65528, 127, 0, 0, 0, 0);
		add_row(OP_CREATE,     0,  0,  2,    17,   3, 0, 0, 0, 0);
		add_row(OP_CREATE,     0,  0,  3,     7,   0, 0, 0, 0, 0);
		add_row(OP_CREATE,     0,  0,  4,  4096,  60, 0, 0, 0, 0);
		add_row(OP_CREATE,     0,  0, 63,    24,   1, 0, 0, 0, 0);
		add_row(OP_CREATE,     0,  0,  5,     8,   2, 1, 0, 0, 0);
		add_row(OP_DESTROY,    4,  0,  0,     0,   0, 1, 1, 0, 0);
		add_row(OP_CREATE,     0,  0,  0,    40,   0, 0, 0, 0, 0);
		add_row(OP_ALLOC,      4,  0,  0,     0,   0, 1, 0, 0, 0);
		add_row(OP_ALLOC,      1,  0,  0,     0,   0, 0, 0, 0, 0);
		add_row(OP_FIND_FIRST, 9,  0,  0,     0,   0, 1, 0, 0, 0);
	endtask

	// drive one request beat and hold it until accepted
	task automatic send_request(input req_t r, input bit allow_gap);
		outcome_t o;
		int n;
		if (allow_gap && $urandom_range(99) < 25) begin
			n = $urandom_range(6, 1);
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		operation <= r.op;
		pool_handle <= r.ph;
		slot_handle <= r.sh;
		slot_count <= r.cnt;
		item_bytes <= r.bytes;
		grow_step <= r.step;
		forever begin
			@(posedge clk);
			if (!busy) begin
				break;
			end
		end
		o = pool_outcome(r);
		if (r.typed) begin
			o = '{r.e_ok, r.e_h, r.e_off};
		end
		outcome_q.push_back(o);
	endtask

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				e = outcome_q.pop_front();
				if (ok !== e.ok) begin
					report_mismatch($sformatf("ok got %b exp %b", ok, e.ok));
				end
				if (handle_out !== e.h) begin
					report_mismatch($sformatf("handle_out got %0d exp %0d", handle_out, e.h));
				end
				if (byte_offset !== e.off) begin
					report_mismatch($sformatf("byte_offset got %0d exp %0d",
						byte_offset, e.off));
				end
			end
		end
	end

	initial begin
		int n;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_CREATE;
		pool_handle = '0;
		slot_handle = '0;
		slot_count = '0;
		item_bytes = '0;
		grow_step = '0;
		for (int k = 0; k < NUM_POOLS; k++) begin
			pool_used[k] = 1'b0;
			pool_cap[k] = 0;
			pool_size[k] = '0;
			pool_grow[k] = 0;
			pool_taken[k] = '0;
		end
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		load_directed();
		foreach (directed_rows[k]) begin
			send_request(directed_rows[k], 1'b1);
		end
		for (int k = 0; k < RANDOM_REQS; k++) begin
			send_request(random_request(), k < RANDOM_REQS - QUIET_TAIL);
		end
		@(negedge clk);
		start <= 1'b0;
		n = 0;
		while (outcome_q.size() != 0 && n < 1000) begin
			@(posedge clk);
			n++;
		end
		repeat (4) @(posedge clk);
		if (outcome_q.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never arrived", outcome_q.size()));
		end
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
